// File: rtl/pcr_pkg.sv
package pcr_pkg;

   localparam int META_W = 9;
   localparam int REMAP_W = 8;
   localparam int RGB_W = 24;
   localparam int COUNT_W = 9;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_MARK    = 3'd1,
      OP_PWRITE  = 3'd2,
      OP_COMPACT = 3'd3,
      OP_XLATE   = 3'd4,
      OP_PREAD   = 3'd5
   } op_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_MARK,
      ST_XLATE,
      ST_PREAD,
      ST_LO_RD,
      ST_LO_CHK,
      ST_HI_RD,
      ST_HI_CHK,
      ST_MOVE,
      ST_MOVE_LO,
      ST_DONE
   } state_type;

endpackage

// File: rtl/palette_compaction_remap.sv
// Indexed palette compactor. Each color slot holds a used flag and a remap entry in one
// single-port-read metadata memory, and its RGB value in a palette memory. After reset, and
// after every clear item, the block sweeps the metadata memory (used flags cleared, remap
// set to identity) and takes no item meanwhile. A palette write is done in the idle state, a
// mark is read, then written back. Translate and palette read read their memory, then load
// the result into the output register once it is free; the result then sits there while the
// next item is already taken. A compact item walks the metadata memory with two pointers,
// each pointer step a read state then a check state, and each move a copy state then a write
// state; the one read port of the metadata memory is why each step reads, then checks.
module palette_compaction_remap
   import pcr_pkg::*;
#(
   parameter int NUM_COLORS = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [2:0]   req_op,
   input  logic [7:0]   req_color_index,
   input  logic [7:0]   req_red_in,
   input  logic [7:0]   req_green_in,
   input  logic [7:0]   req_blue_in,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_mapped_index,
   output logic [7:0]   rsp_red_out,
   output logic [7:0]   rsp_green_out,
   output logic [7:0]   rsp_blue_out,
   output logic [8:0]   rsp_colors_in_use
);

   localparam int AW = $clog2(NUM_COLORS);
   localparam int CNT_W = AW + 1;
   localparam int CMP_W = ((AW > 8) ? AW : 8) + 1;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] lo_ff, lo_in;
   logic [CNT_W-1:0] hp_ff, hp_in;
   logic [7:0] idx_ff, idx_in;
   logic idx_ok_ff, idx_ok_in;
   logic [REMAP_W-1:0] remap_lo_ff, remap_lo_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_mapped_ff, rsp_mapped_in;
   logic [RGB_W-1:0] rsp_rgb_ff, rsp_rgb_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic m_we, m_re;
   logic [AW-1:0] m_waddr, m_raddr;
   logic [META_W-1:0] m_wdata, m_rdata;
   logic p_we, p_re;
   logic [AW-1:0] p_waddr, p_raddr;
   logic [RGB_W-1:0] p_wdata, p_rdata;

   logic idx_ok;
   logic [AW-1:0] req_addr;
   logic [AW-1:0] lo_addr;
   logic [AW-1:0] hi_addr;
   logic slot_free;

   assign idx_ok = CMP_W'(req_color_index) < CMP_W'(NUM_COLORS);
   assign req_addr = AW'(req_color_index);
   assign lo_addr = AW'(lo_ff);
   assign hi_addr = AW'(hp_ff - CNT_W'(1));
   assign slot_free = !rsp_valid_ff || rsp_ready;

   pcr_ram #(
      .WIDTH (META_W),
      .DEPTH (NUM_COLORS)
   ) u_meta_ram (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_en   (m_re),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   pcr_ram #(
      .WIDTH (RGB_W),
      .DEPTH (NUM_COLORS)
   ) u_palette_ram (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_waddr),
      .wr_data (p_wdata),
      .rd_en   (p_re),
      .rd_addr (p_raddr),
      .rd_data (p_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         lo_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lo_ff <= lo_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hp_ff <= hp_in;
      idx_ff <= idx_in;
      idx_ok_ff <= idx_ok_in;
      remap_lo_ff <= remap_lo_in;
      rsp_mapped_ff <= rsp_mapped_in;
      rsp_rgb_ff <= rsp_rgb_in;
      rsp_count_ff <= rsp_count_in;
   end

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff;
      hp_in = hp_ff;
      idx_in = idx_ff;
      idx_ok_in = idx_ok_ff;
      remap_lo_in = remap_lo_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_mapped_in = rsp_mapped_ff;
      rsp_rgb_in = rsp_rgb_ff;
      rsp_count_in = rsp_count_ff;
      req_ready = 1'b0;
      m_we = 1'b0;
      m_waddr = lo_addr;
      m_wdata = '0;
      m_re = 1'b0;
      m_raddr = req_addr;
      p_we = 1'b0;
      p_waddr = req_addr;
      p_wdata = {req_red_in, req_green_in, req_blue_in};
      p_re = 1'b0;
      p_raddr = req_addr;

      case (state_ff)
         ST_SWEEP: begin
            // identity remap, used flag cleared
            m_we = 1'b1;
            m_wdata = {1'b0, 8'(lo_ff)};
            if (lo_ff == CNT_W'(NUM_COLORS - 1)) begin
               lo_in = '0;
               state_in = ST_IDLE;
            end else begin
               lo_in = lo_ff + CNT_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               idx_in = req_color_index;
               idx_ok_in = idx_ok;
               case (req_op)
                  OP_CLEAR: begin
                     lo_in = '0;
                     state_in = ST_SWEEP;
                  end
                  OP_MARK: begin
                     if (idx_ok) begin
                        m_re = 1'b1;
                        state_in = ST_MARK;
                     end
                  end
                  OP_PWRITE: begin
                     p_we = idx_ok;
                  end
                  OP_COMPACT: begin
                     lo_in = '0;
                     hp_in = CNT_W'(NUM_COLORS);
                     state_in = ST_LO_RD;
                  end
                  OP_XLATE: begin
                     m_re = idx_ok;
                     state_in = ST_XLATE;
                  end
                  OP_PREAD: begin
                     p_re = idx_ok;
                     state_in = ST_PREAD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MARK: begin
            m_we = 1'b1;
            m_waddr = AW'(idx_ff);
            m_wdata = {1'b1, m_rdata[REMAP_W-1:0]};
            state_in = ST_IDLE;
         end
         ST_XLATE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mapped_in = idx_ok_ff ? m_rdata[REMAP_W-1:0] : idx_ff;
               rsp_rgb_in = '0;
               rsp_count_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_PREAD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mapped_in = '0;
               rsp_rgb_in = idx_ok_ff ? p_rdata : '0;
               rsp_count_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_LO_RD: begin
            if (lo_ff == CNT_W'(NUM_COLORS)) begin
               state_in = ST_DONE;
            end else begin
               m_re = 1'b1;
               m_raddr = lo_addr;
               state_in = ST_LO_CHK;
            end
         end
         ST_LO_CHK: begin
            if (m_rdata[META_W-1]) begin
               lo_in = lo_ff + CNT_W'(1);
               state_in = ST_LO_RD;
            end else begin
               remap_lo_in = m_rdata[REMAP_W-1:0];
               state_in = ST_HI_RD;
            end
         end
         ST_HI_RD: begin
            if (hp_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               m_re = 1'b1;
               m_raddr = hi_addr;
               state_in = ST_HI_CHK;
            end
         end
         ST_HI_CHK: begin
            if (!m_rdata[META_W-1]) begin
               hp_in = hp_ff - CNT_W'(1);
               state_in = ST_HI_RD;
            end else if (hp_ff <= lo_ff + CNT_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               p_re = 1'b1;
               p_raddr = hi_addr;
               state_in = ST_MOVE;
            end
         end
         ST_MOVE: begin
            // copy entry down and record the move
            p_we = 1'b1;
            p_waddr = lo_addr;
            p_wdata = p_rdata;
            m_we = 1'b1;
            m_waddr = hi_addr;
            m_wdata = {1'b0, 8'(lo_ff)};
            state_in = ST_MOVE_LO;
         end
         ST_MOVE_LO: begin
            m_we = 1'b1;
            m_waddr = lo_addr;
            m_wdata = {1'b1, remap_lo_ff};
            lo_in = lo_ff + CNT_W'(1);
            hp_in = hp_ff - CNT_W'(1);
            state_in = ST_LO_RD;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mapped_in = '0;
               rsp_rgb_in = '0;
               rsp_count_in = COUNT_W'(hp_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_mapped_index = rsp_mapped_ff;
   assign rsp_red_out = rsp_rgb_ff[23:16];
   assign rsp_green_out = rsp_rgb_ff[15:8];
   assign rsp_blue_out = rsp_rgb_ff[7:0];
   assign rsp_colors_in_use = rsp_count_ff;

endmodule

// File: rtl/pcr_ram.sv
module pcr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
